### hdl/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// Shared constants, opcodes and the control word of the complex arithmetic
// unit pipeline.
// ----------------------------------------------------------------------------
package cau_pkg;

   // default number format, signed Q3.12
   localparam int CAU_FRAC_BITS  = 12;
   localparam int CAU_DATA_WIDTH = 16;

   // opcodes
   typedef logic [2:0] cau_op_type;
   localparam cau_op_type OP_ADD   = 3'd0;
   localparam cau_op_type OP_SUB   = 3'd1;
   localparam cau_op_type OP_MUL   = 3'd2;
   localparam cau_op_type OP_DIV   = 3'd3;
   localparam cau_op_type OP_SCALE = 3'd4;
   localparam cau_op_type OP_CONJ  = 3'd5;
   localparam cau_op_type OP_INV   = 3'd6;
   localparam cau_op_type OP_DIVR  = 3'd7;

   // control word that travels with every beat down the divider chain
   typedef struct packed {
      logic valid;
      logic is_div;
      logic dz;
      logic neg_re;
      logic neg_im;
      logic sat;
      logic ovf_re;
      logic ovf_im;
   } cau_ctl_type;

endpackage

### hdl/cau_div_cell.sv
// ----------------------------------------------------------------------------
// cau_div_cell
// One restoring division step for the real and imaginary lanes: shifts in
// one dividend bit, trial-subtracts the divisor and emits one quotient bit.
// ----------------------------------------------------------------------------
module cau_div_cell #(
   parameter int W  = 16,
   parameter int DW = 32,
   parameter int QW = 18
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cau_pkg::cau_ctl_type ctl_in,
   input  logic [DW-1:0]        d_in,
   input  logic [DW-1:0]        r_re_in,
   input  logic [DW-1:0]        r_im_in,
   input  logic [QW-1:0]        x_re_in,
   input  logic [QW-1:0]        x_im_in,
   input  logic [QW-1:0]        q_re_in,
   input  logic [QW-1:0]        q_im_in,
   input  logic [W-1:0]         dir_re_in,
   input  logic [W-1:0]         dir_im_in,
   output cau_pkg::cau_ctl_type ctl_out,
   output logic [DW-1:0]        d_out,
   output logic [DW-1:0]        r_re_out,
   output logic [DW-1:0]        r_im_out,
   output logic [QW-1:0]        x_re_out,
   output logic [QW-1:0]        x_im_out,
   output logic [QW-1:0]        q_re_out,
   output logic [QW-1:0]        q_im_out,
   output logic [W-1:0]         dir_re_out,
   output logic [W-1:0]         dir_im_out
);
   import cau_pkg::*;

   cau_ctl_type   ctl_ff;
   logic [DW-1:0] d_ff, r_re_ff, r_im_ff, r_re_in_n, r_im_in_n;
   logic [QW-1:0] x_re_ff, x_im_ff, q_re_ff, q_im_ff;
   logic [W-1:0]  dir_re_ff, dir_im_ff;
   logic [DW:0]   t_re, t_im;
   logic          ge_re, ge_im;

   // trial subtract on both lanes
   always_comb begin
      t_re      = {r_re_in, x_re_in[QW-1]};
      t_im      = {r_im_in, x_im_in[QW-1]};
      ge_re     = t_re >= {1'b0, d_in};
      ge_im     = t_im >= {1'b0, d_in};
      r_re_in_n = ge_re ? DW'(t_re - {1'b0, d_in}) : DW'(t_re);
      r_im_in_n = ge_im ? DW'(t_im - {1'b0, d_in}) : DW'(t_im);
   end

   // control word
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      d_ff      <= d_in;
      r_re_ff   <= r_re_in_n;
      r_im_ff   <= r_im_in_n;
      x_re_ff   <= {x_re_in[QW-2:0], 1'b0};
      x_im_ff   <= {x_im_in[QW-2:0], 1'b0};
      q_re_ff   <= {q_re_in[QW-2:0], ge_re};
      q_im_ff   <= {q_im_in[QW-2:0], ge_im};
      dir_re_ff <= dir_re_in;
      dir_im_ff <= dir_im_in;
   end

   assign ctl_out    = ctl_ff;
   assign d_out      = d_ff;
   assign r_re_out   = r_re_ff;
   assign r_im_out   = r_im_ff;
   assign x_re_out   = x_re_ff;
   assign x_im_out   = x_im_ff;
   assign q_re_out   = q_re_ff;
   assign q_im_out   = q_im_ff;
   assign dir_re_out = dir_re_ff;
   assign dir_im_out = dir_im_ff;

endmodule

### hdl/cau_divider.sv
// ----------------------------------------------------------------------------
// cau_divider
// Pipelined fractional divider: an entry stage splits the scaled dividend
// and checks for quotient overflow, then a row of division cells produces
// one quotient bit each.
// ----------------------------------------------------------------------------
module cau_divider #(
   parameter int W = 16,
   parameter int F = 12
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  cau_pkg::cau_ctl_type                        ctl_in,
   input  logic [((2*W > W+F) ? 2*W : W+F)-1:0]        n_re_in,
   input  logic [((2*W > W+F) ? 2*W : W+F)-1:0]        n_im_in,
   input  logic [2*W-1:0]                              d_in,
   input  logic [W-1:0]                                dir_re_in,
   input  logic [W-1:0]                                dir_im_in,
   output cau_pkg::cau_ctl_type                        ctl_out,
   output logic [2*W-1:0]                              d_out,
   output logic [2*W-1:0]                              r_re_out,
   output logic [2*W-1:0]                              r_im_out,
   output logic [W+1:0]                                q_re_out,
   output logic [W+1:0]                                q_im_out,
   output logic [W-1:0]                                dir_re_out,
   output logic [W-1:0]                                dir_im_out
);
   import cau_pkg::*;

   localparam int NW = (2*W > W+F) ? 2*W : W+F;
   localparam int DW = 2*W;
   localparam int QW = W+2;
   localparam int XW = NW+F;
   localparam int HW = XW-QW;
   localparam int CW = (HW > DW) ? HW : DW;

   logic [XW-1:0] x_re, x_im;
   logic          ovf_re_in, ovf_im_in;
   cau_ctl_type   ctl_ent_in;

   cau_ctl_type   ent_ctl_ff;
   logic [DW-1:0] ent_d_ff, ent_r_re_ff, ent_r_im_ff;
   logic [QW-1:0] ent_x_re_ff, ent_x_im_ff;
   logic [W-1:0]  ent_dir_re_ff, ent_dir_im_ff;

   cau_ctl_type   c_ctl [0:QW];
   logic [DW-1:0] c_d   [0:QW];
   logic [DW-1:0] c_rre [0:QW];
   logic [DW-1:0] c_rim [0:QW];
   logic [QW-1:0] c_xre [0:QW];
   logic [QW-1:0] c_xim [0:QW];
   logic [QW-1:0] c_qre [0:QW];
   logic [QW-1:0] c_qim [0:QW];
   logic [W-1:0]  c_dre [0:QW];
   logic [W-1:0]  c_dim [0:QW];

   // scaled dividend and overflow check on the top part
   always_comb begin
      x_re       = {n_re_in, {F{1'b0}}};
      x_im       = {n_im_in, {F{1'b0}}};
      ovf_re_in  = CW'(x_re[XW-1:QW]) >= CW'(d_in);
      ovf_im_in  = CW'(x_im[XW-1:QW]) >= CW'(d_in);
      ctl_ent_in = ctl_in;
      ctl_ent_in.ovf_re = ovf_re_in;
      ctl_ent_in.ovf_im = ovf_im_in;
   end

   // entry stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         ent_ctl_ff <= '0;
      end else begin
         ent_ctl_ff <= ctl_ent_in;
      end
   end

   // entry stage payload
   always_ff @(posedge clock) begin
      ent_d_ff      <= d_in;
      ent_r_re_ff   <= ovf_re_in ? '0 : DW'(x_re[XW-1:QW]);
      ent_r_im_ff   <= ovf_im_in ? '0 : DW'(x_im[XW-1:QW]);
      ent_x_re_ff   <= x_re[QW-1:0];
      ent_x_im_ff   <= x_im[QW-1:0];
      ent_dir_re_ff <= dir_re_in;
      ent_dir_im_ff <= dir_im_in;
   end

   assign c_ctl[0] = ent_ctl_ff;
   assign c_d[0]   = ent_d_ff;
   assign c_rre[0] = ent_r_re_ff;
   assign c_rim[0] = ent_r_im_ff;
   assign c_xre[0] = ent_x_re_ff;
   assign c_xim[0] = ent_x_im_ff;
   assign c_qre[0] = '0;
   assign c_qim[0] = '0;
   assign c_dre[0] = ent_dir_re_ff;
   assign c_dim[0] = ent_dir_im_ff;

   // row of division cells, one quotient bit each
   for (genvar i = 0; i < QW; i++) begin : g_cell
      cau_div_cell #(.W(W), .DW(DW), .QW(QW)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl_in     (c_ctl[i]),
         .d_in       (c_d[i]),
         .r_re_in    (c_rre[i]),
         .r_im_in    (c_rim[i]),
         .x_re_in    (c_xre[i]),
         .x_im_in    (c_xim[i]),
         .q_re_in    (c_qre[i]),
         .q_im_in    (c_qim[i]),
         .dir_re_in  (c_dre[i]),
         .dir_im_in  (c_dim[i]),
         .ctl_out    (c_ctl[i+1]),
         .d_out      (c_d[i+1]),
         .r_re_out   (c_rre[i+1]),
         .r_im_out   (c_rim[i+1]),
         .x_re_out   (c_xre[i+1]),
         .x_im_out   (c_xim[i+1]),
         .q_re_out   (c_qre[i+1]),
         .q_im_out   (c_qim[i+1]),
         .dir_re_out (c_dre[i+1]),
         .dir_im_out (c_dim[i+1])
      );
   end

   assign ctl_out    = c_ctl[QW];
   assign d_out      = c_d[QW];
   assign r_re_out   = c_rre[QW];
   assign r_im_out   = c_rim[QW];
   assign q_re_out   = c_qre[QW];
   assign q_im_out   = c_qim[QW];
   assign dir_re_out = c_dre[QW];
   assign dir_im_out = c_dim[QW];

endmodule

### hdl/complex_arithmetic_unit_core.sv
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_core
// Complex ALU in signed fixed point: add, sub, mul, div, scale, conj,
// invert and divide by real, rounded to nearest and saturated.
//
//   channel   ports                          handshake
//   request   req_op, req_a_*, req_b_*       start high, busy low
//   response  rsp_res_*, rsp_div_by_zero,    rsp_valid, one cycle
//             rsp_saturated
//
// A beat enters every cycle while busy is low; its result passes the request,
// product, sum and divider setup stages, the divider entry stage and the chain
// of division cells (one quotient bit a cell), then the response register.
// All ops travel the same pipeline so results leave in request order.
// busy is high only while reset is held and for the cycle after it.
// Reset clears the valid bits of every stage; data in flight is dropped.
// The receiver cannot stall, so nothing holds the pipeline back.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_core #(
   parameter int FRAC_BITS  = cau_pkg::CAU_FRAC_BITS,
   parameter int DATA_WIDTH = cau_pkg::CAU_DATA_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  cau_pkg::cau_op_type          req_op,
   input  logic signed [DATA_WIDTH-1:0] req_a_re,
   input  logic signed [DATA_WIDTH-1:0] req_a_im,
   input  logic signed [DATA_WIDTH-1:0] req_b_re,
   input  logic signed [DATA_WIDTH-1:0] req_b_im,
   output logic                         rsp_valid,
   output logic signed [DATA_WIDTH-1:0] rsp_res_re,
   output logic signed [DATA_WIDTH-1:0] rsp_res_im,
   output logic                         rsp_div_by_zero,
   output logic                         rsp_saturated
);
   import cau_pkg::*;

   localparam int W   = DATA_WIDTH;
   localparam int F   = FRAC_BITS;
   localparam int MW  = 2*W+1;
   localparam int NW  = (2*W > W+F) ? 2*W : W+F;
   localparam int DW  = 2*W;
   localparam int QW  = W+2;
   localparam int LAT = QW+6;
   localparam logic [W-1:0]  POS_MAX_W = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0]  MIN_W     = {1'b1, {(W-1){1'b0}}};
   localparam logic [MW-1:0] HALF      = MW'(1) << (F-1);

   // clip sign and magnitude to the W-bit range, {sat, value}
   function automatic logic [W:0] clip_fn(input logic neg, input logic [MW-1:0] mag);
      logic [W:0] r;
      if (!neg) begin
         if (mag > MW'(POS_MAX_W)) r = {1'b1, POS_MAX_W};
         else                      r = {1'b0, mag[W-1:0]};
      end else begin
         if (mag > MW'(MIN_W)) r = {1'b1, MIN_W};
         else                  r = {1'b0, W'(-mag[W-1:0])};
      end
      return r;
   endfunction

   logic accept;
   logic busy_ff;

   // stage 1: request registers
   logic                v1_ff;
   cau_op_type          op1_ff;
   logic signed [W-1:0] ar1_ff, ai1_ff, br1_ff, bi1_ff;

   // stage 2: products and simple sums
   logic                  v2_ff;
   cau_op_type            op2_ff;
   logic signed [W-1:0]   ar2_ff, ai2_ff, br2_ff, sx, sy;
   logic signed [2*W-1:0] m0_in, m1_in, m2_in, m3_in, m4_in, m5_in;
   logic signed [2*W-1:0] m0_ff, m1_ff, m2_ff, m3_ff, m4_ff, m5_ff;
   logic signed [W:0]     ar1x, ai1x, br1x, bi1x, dre_in, dim_in, dre2_ff, dim2_ff;

   // stage 3: product sums
   logic                  v3_ff;
   cau_op_type            op3_ff;
   logic signed [W-1:0]   ar3_ff, ai3_ff, br3_ff;
   logic signed [W:0]     dre3_ff, dim3_ff;
   logic signed [MW-1:0]  re_sum_in, im_sum_in, re_sum_ff, im_sum_ff;
   logic [DW-1:0]         den_in, den_ff;

   // stage 4: divider setup and direct results
   cau_ctl_type   ctl4_in, ctl4_ff;
   logic [NW-1:0] n_re_in, n_im_in, n_re_ff, n_im_ff;
   logic [DW-1:0] d4_in, d4_ff;
   logic [W-1:0]  dir_re_in, dir_im_in, dir_re_ff, dir_im_ff;
   logic [MW-1:0] re_mag, im_mag, dmag_re, dmag_im;
   logic [W-1:0]  abs_ar, abs_ai, abs_br;
   logic          dneg_re, dneg_im;
   logic [W:0]    clip_re, clip_im;

   // divider outputs
   cau_ctl_type   dv_ctl;
   logic [DW-1:0] dv_d, dv_r_re, dv_r_im;
   logic [QW-1:0] dv_q_re, dv_q_im;
   logic [W-1:0]  dv_dir_re, dv_dir_im;

   // output stage
   logic [QW:0]   qr_re, qr_im;
   logic [W:0]    oc_re, oc_im;
   logic          rsp_valid_in, dz_in, sat_in;
   logic [W-1:0]  res_re_in, res_im_in;
   logic          rsp_valid_ff, dz_ff, sat_ff;
   logic [W-1:0]  res_re_ff, res_im_ff;

   assign accept = start && !busy_ff;
   assign busy   = busy_ff;

   // busy through reset
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   // valid bits of the front stages
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         ctl4_ff <= '0;
      end else begin
         v1_ff   <= accept;
         v2_ff   <= v1_ff;
         v3_ff   <= v2_ff;
         ctl4_ff <= ctl4_in;
      end
   end

   // stage 1 capture
   always_ff @(posedge clock) begin
      op1_ff <= req_op;
      ar1_ff <= req_a_re;
      ai1_ff <= req_a_im;
      br1_ff <= req_b_re;
      bi1_ff <= req_b_im;
   end

   // stage 2: multipliers, squares use the divisor operands, or operand a for invert
   always_comb begin
      sx    = (op1_ff == OP_INV) ? ar1_ff : br1_ff;
      sy    = (op1_ff == OP_INV) ? ai1_ff : bi1_ff;
      m0_in = ar1_ff * br1_ff;
      m1_in = ai1_ff * bi1_ff;
      m2_in = ar1_ff * bi1_ff;
      m3_in = ai1_ff * br1_ff;
      m4_in = sx * sx;
      m5_in = sy * sy;
      ar1x  = {ar1_ff[W-1], ar1_ff};
      ai1x  = {ai1_ff[W-1], ai1_ff};
      br1x  = {br1_ff[W-1], br1_ff};
      bi1x  = {bi1_ff[W-1], bi1_ff};
      case (op1_ff)
         OP_ADD: begin
            dre_in = ar1x + br1x;
            dim_in = ai1x + bi1x;
         end
         OP_SUB: begin
            dre_in = ar1x - br1x;
            dim_in = ai1x - bi1x;
         end
         OP_CONJ: begin
            dre_in = ar1x;
            dim_in = -ai1x;
         end
         default: begin
            dre_in = '0;
            dim_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op2_ff  <= op1_ff;
      ar2_ff  <= ar1_ff;
      ai2_ff  <= ai1_ff;
      br2_ff  <= br1_ff;
      m0_ff   <= m0_in;
      m1_ff   <= m1_in;
      m2_ff   <= m2_in;
      m3_ff   <= m3_in;
      m4_ff   <= m4_in;
      m5_ff   <= m5_in;
      dre2_ff <= dre_in;
      dim2_ff <= dim_in;
   end

   // stage 3: combine products, squared magnitude
   always_comb begin
      den_in = $unsigned(m4_ff) + $unsigned(m5_ff);
      case (op2_ff)
         OP_MUL: begin
            re_sum_in = MW'(m0_ff) - MW'(m1_ff);
            im_sum_in = MW'(m2_ff) + MW'(m3_ff);
         end
         OP_DIV: begin
            re_sum_in = MW'(m0_ff) + MW'(m1_ff);
            im_sum_in = MW'(m3_ff) - MW'(m2_ff);
         end
         OP_SCALE: begin
            re_sum_in = MW'(m0_ff);
            im_sum_in = MW'(m3_ff);
         end
         default: begin
            re_sum_in = '0;
            im_sum_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op3_ff    <= op2_ff;
      ar3_ff    <= ar2_ff;
      ai3_ff    <= ai2_ff;
      br3_ff    <= br2_ff;
      dre3_ff   <= dre2_ff;
      dim3_ff   <= dim2_ff;
      re_sum_ff <= re_sum_in;
      im_sum_ff <= im_sum_in;
      den_ff    <= den_in;
   end

   // stage 4: magnitudes, rounding of products, divider operands
   always_comb begin
      re_mag  = re_sum_ff[MW-1] ? $unsigned(-re_sum_ff) : $unsigned(re_sum_ff);
      im_mag  = im_sum_ff[MW-1] ? $unsigned(-im_sum_ff) : $unsigned(im_sum_ff);
      abs_ar  = ar3_ff[W-1] ? $unsigned(-ar3_ff) : $unsigned(ar3_ff);
      abs_ai  = ai3_ff[W-1] ? $unsigned(-ai3_ff) : $unsigned(ai3_ff);
      abs_br  = br3_ff[W-1] ? $unsigned(-br3_ff) : $unsigned(br3_ff);
      dneg_re = dre3_ff[W];
      dneg_im = dim3_ff[W];
      dmag_re = MW'(dre3_ff[W] ? $unsigned(-dre3_ff) : $unsigned(dre3_ff));
      dmag_im = MW'(dim3_ff[W] ? $unsigned(-dim3_ff) : $unsigned(dim3_ff));
      ctl4_in       = '0;
      ctl4_in.valid = v3_ff;
      n_re_in       = '0;
      n_im_in       = '0;
      d4_in         = den_ff;
      case (op3_ff)
         OP_MUL, OP_SCALE: begin
            dneg_re = re_sum_ff[MW-1];
            dneg_im = im_sum_ff[MW-1];
            dmag_re = (re_mag + HALF) >> F;
            dmag_im = (im_mag + HALF) >> F;
         end
         OP_DIV: begin
            ctl4_in.is_div = 1'b1;
            ctl4_in.dz     = den_ff == '0;
            ctl4_in.neg_re = re_sum_ff[MW-1];
            ctl4_in.neg_im = im_sum_ff[MW-1];
            n_re_in        = NW'(re_mag);
            n_im_in        = NW'(im_mag);
         end
         OP_INV: begin
            ctl4_in.is_div = 1'b1;
            ctl4_in.dz     = den_ff == '0;
            ctl4_in.neg_re = ar3_ff[W-1];
            ctl4_in.neg_im = !ai3_ff[W-1];
            n_re_in        = NW'({abs_ar, {F{1'b0}}});
            n_im_in        = NW'({abs_ai, {F{1'b0}}});
         end
         OP_DIVR: begin
            ctl4_in.is_div = 1'b1;
            ctl4_in.dz     = br3_ff == '0;
            ctl4_in.neg_re = ar3_ff[W-1] ^ br3_ff[W-1];
            ctl4_in.neg_im = ai3_ff[W-1] ^ br3_ff[W-1];
            n_re_in        = NW'(abs_ar);
            n_im_in        = NW'(abs_ai);
            d4_in          = DW'(abs_br);
         end
         default: begin
         end
      endcase
      clip_re     = clip_fn(dneg_re, dmag_re);
      clip_im     = clip_fn(dneg_im, dmag_im);
      dir_re_in   = clip_re[W-1:0];
      dir_im_in   = clip_im[W-1:0];
      ctl4_in.sat = !ctl4_in.is_div && (clip_re[W] || clip_im[W]);
   end

   always_ff @(posedge clock) begin
      n_re_ff   <= n_re_in;
      n_im_ff   <= n_im_in;
      d4_ff     <= d4_in;
      dir_re_ff <= dir_re_in;
      dir_im_ff <= dir_im_in;
   end

   // divider chain
   cau_divider #(.W(W), .F(F)) u_divider (
      .clock      (clock),
      .reset      (reset),
      .ctl_in     (ctl4_ff),
      .n_re_in    (n_re_ff),
      .n_im_in    (n_im_ff),
      .d_in       (d4_ff),
      .dir_re_in  (dir_re_ff),
      .dir_im_in  (dir_im_ff),
      .ctl_out    (dv_ctl),
      .d_out      (dv_d),
      .r_re_out   (dv_r_re),
      .r_im_out   (dv_r_im),
      .q_re_out   (dv_q_re),
      .q_im_out   (dv_q_im),
      .dir_re_out (dv_dir_re),
      .dir_im_out (dv_dir_im)
   );

   // round quotient, clip, pick result
   always_comb begin
      qr_re = {1'b0, dv_q_re} + (QW+1)'({dv_r_re, 1'b0} >= {1'b0, dv_d});
      qr_im = {1'b0, dv_q_im} + (QW+1)'({dv_r_im, 1'b0} >= {1'b0, dv_d});
      oc_re = clip_fn(dv_ctl.neg_re, dv_ctl.ovf_re ? {MW{1'b1}} : MW'(qr_re));
      oc_im = clip_fn(dv_ctl.neg_im, dv_ctl.ovf_im ? {MW{1'b1}} : MW'(qr_im));
      rsp_valid_in = dv_ctl.valid;
      dz_in        = 1'b0;
      if (!dv_ctl.is_div) begin
         res_re_in = dv_dir_re;
         res_im_in = dv_dir_im;
         sat_in    = dv_ctl.sat;
      end else if (dv_ctl.dz) begin
         res_re_in = '0;
         res_im_in = '0;
         sat_in    = 1'b0;
         dz_in     = 1'b1;
      end else begin
         res_re_in = oc_re[W-1:0];
         res_im_in = oc_im[W-1:0];
         sat_in    = oc_re[W] || oc_im[W];
      end
   end

   // response strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response beat
   always_ff @(posedge clock) begin
      res_re_ff <= res_re_in;
      res_im_ff <= res_im_in;
      dz_ff     <= dz_in;
      sat_ff    <= sat_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_res_re      = res_re_ff;
   assign rsp_res_im      = res_im_ff;
   assign rsp_div_by_zero = dz_ff;
   assign rsp_saturated   = sat_ff;

   // every response beat comes from a request beat a fixed latency earlier
   a_latency : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LAT))
      else $error("response without matching request");

   // a zero divisor returns zero without saturation
   a_dz_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_div_by_zero |->
         rsp_res_re == '0 && rsp_res_im == '0 && !rsp_saturated)
      else $error("divide by zero result not cleared");

   // a saturated beat has a part at a range end
   a_sat_end : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         rsp_res_re == POS_MAX_W || rsp_res_re == MIN_W ||
         rsp_res_im == POS_MAX_W || rsp_res_im == MIN_W)
      else $error("saturation flag without clipped part");

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the complex arithmetic unit core. Every accepted
// request beat is predicted in a scoreboard and each response beat is checked
// in order against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cau_pkg::*;

   localparam int W  = CAU_DATA_WIDTH;
   localparam int FB = CAU_FRAC_BITS;
   localparam longint POS_MAX = (longint'(1) <<< (W - 1)) - 1;
   localparam longint NEG_MIN = -(longint'(1) <<< (W - 1));
   localparam logic signed [W-1:0] MAX_W = W'(POS_MAX);
   localparam logic signed [W-1:0] MIN_W = W'(NEG_MIN);

   typedef struct {
      logic signed [W-1:0] re;
      logic signed [W-1:0] im;
      logic                dz;
      logic                sat;
   } cplx_result_type;

   // complex math predictor and in-order store of expected results
   class cplx_scoreboard;
      cplx_result_type expected_q[$];
      int              errors;

      // round(num * 2^FB / den) with ties up, capped once far out of range
      function longint unsigned div_frac(longint unsigned num, longint unsigned den);
         longint unsigned lim;
         longint unsigned q;
         longint unsigned r;
         bit              big;
         bit              qbit;
         lim = longint'(1) << W;
         q   = num / den;
         r   = num % den;
         big = q > lim;
         for (int i = 0; i < FB; i++) begin
            r    = r << 1;
            qbit = r >= den;
            if (qbit) r = r - den;
            if (!big) begin
               q = (q << 1) | qbit;
               if (q > lim) big = 1;
            end
         end
         if (big) return lim << 1;
         if (r >= den - r) q++;
         return q;
      endfunction

      // drop the fraction bits, half away from zero
      function longint round_frac(longint x);
         longint m;
         m = (x < 0) ? -x : x;
         m = (m + (longint'(1) <<< (FB - 1))) >>> FB;
         return (x < 0) ? -m : m;
      endfunction

      function longint quotient(longint n, longint unsigned den, bit flip);
         longint unsigned m;
         longint q;
         m = (n < 0) ? -n : n;
         q = longint'(div_frac(m, den));
         return ((n < 0) ^ flip) ? -q : q;
      endfunction

      function logic signed [W-1:0] clip(longint x, inout logic sat);
         if (x > POS_MAX) begin
            sat = 1;
            return MAX_W;
         end
         if (x < NEG_MIN) begin
            sat = 1;
            return MIN_W;
         end
         return W'(x);
      endfunction

      // predict the result of one accepted request beat
      function void note_request(cau_op_type op, logic signed [W-1:0] a_re,
                                 logic signed [W-1:0] a_im, logic signed [W-1:0] b_re,
                                 logic signed [W-1:0] b_im);
         longint ar, ai, br, bi, re, im;
         longint unsigned den;
         cplx_result_type res;
         ar = a_re; ai = a_im; br = b_re; bi = b_im;
         re = 0; im = 0;
         res.dz = 0; res.sat = 0;
         case (op)
            OP_ADD: begin
               re = ar + br; im = ai + bi;
            end
            OP_SUB: begin
               re = ar - br; im = ai - bi;
            end
            OP_MUL: begin
               re = round_frac(ar * br - ai * bi);
               im = round_frac(ar * bi + ai * br);
            end
            OP_DIV: begin
               den = br * br + bi * bi;
               if (den == 0) res.dz = 1;
               else begin
                  re = quotient(ar * br + ai * bi, den, 0);
                  im = quotient(ai * br - ar * bi, den, 0);
               end
            end
            OP_SCALE: begin
               re = round_frac(ar * br);
               im = round_frac(ai * br);
            end
            OP_CONJ: begin
               re = ar; im = -ai;
            end
            OP_INV: begin
               den = ar * ar + ai * ai;
               if (den == 0) res.dz = 1;
               else begin
                  re = quotient(ar <<< FB, den, 0);
                  im = quotient(-(ai <<< FB), den, 0);
               end
            end
            default: begin
               if (br == 0) res.dz = 1;
               else begin
                  den = (br < 0) ? -br : br;
                  re  = quotient(ar, den, br < 0);
                  im  = quotient(ai, den, br < 0);
               end
            end
         endcase
         res.re = clip(re, res.sat);
         res.im = clip(im, res.sat);
         expected_q.push_back(res);
      endfunction

      // compare one response beat with the oldest prediction
      function void check_result(logic signed [W-1:0] re, logic signed [W-1:0] im,
                                 logic dz, logic sat);
         cplx_result_type e;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected response re=%0d im=%0d dz=%b sat=%b",
                     $time, re, im, dz, sat);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (re !== e.re) begin
            $display("%0t: res_re expected %0d actual %0d", $time, e.re, re);
            errors++;
         end
         if (im !== e.im) begin
            $display("%0t: res_im expected %0d actual %0d", $time, e.im, im);
            errors++;
         end
         if (dz !== e.dz) begin
            $display("%0t: div_by_zero expected %b actual %b", $time, e.dz, dz);
            errors++;
         end
         if (sat !== e.sat) begin
            $display("%0t: saturated expected %b actual %b", $time, e.sat, sat);
            errors++;
         end
      endfunction
   endclass

   logic                clock = 0;
   logic                reset = 1;
   logic                start = 0;
   logic                busy;
   cau_op_type          req_op = OP_ADD;
   logic signed [W-1:0] req_a_re = 0;
   logic signed [W-1:0] req_a_im = 0;
   logic signed [W-1:0] req_b_re = 0;
   logic signed [W-1:0] req_b_im = 0;
   logic                rsp_valid;
   logic signed [W-1:0] rsp_res_re;
   logic signed [W-1:0] rsp_res_im;
   logic                rsp_div_by_zero;
   logic                rsp_saturated;

   cplx_scoreboard sb = new();
   int             idle_pct;

   always #5 clock = ~clock;

   complex_arithmetic_unit_core DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_a_re(req_a_re), .req_a_im(req_a_im),
      .req_b_re(req_b_re), .req_b_im(req_b_im),
      .rsp_valid(rsp_valid), .rsp_res_re(rsp_res_re), .rsp_res_im(rsp_res_im),
      .rsp_div_by_zero(rsp_div_by_zero), .rsp_saturated(rsp_saturated)
   );

   // observe both channels at the edge that moves each beat
   always @(posedge clock) begin
      if (!reset && start && !busy)
         sb.note_request(req_op, req_a_re, req_a_im, req_b_re, req_b_im);
      if (!reset && rsp_valid)
         sb.check_result(rsp_res_re, rsp_res_im, rsp_div_by_zero, rsp_saturated);
   end

   // present one request beat and hold it until accepted
   task automatic send_beat(cau_op_type op, logic signed [W-1:0] ar,
                            logic signed [W-1:0] ai, logic signed [W-1:0] br,
                            logic signed [W-1:0] bi);
      req_op   <= op;
      req_a_re <= ar;
      req_a_im <= ai;
      req_b_re <= br;
      req_b_im <= bi;
      start    <= 1;
      do @(negedge clock); while (busy);
      @(posedge clock);
      // random gap after the beat
      if ($urandom_range(99) < idle_pct) begin
         start <= 0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
   endtask

   // operand mix: range ends, tiny values, and full random
   function automatic logic signed [W-1:0] pick_value();
      case ($urandom_range(9))
         0: return MIN_W;
         1: return MAX_W;
         2: return '0;
         3: return W'($urandom_range(8) - 4);
         4: return W'($urandom_range(1 << FB) - (1 << (FB - 1)));
         default: return W'($urandom);
      endcase
   endfunction

   initial begin
      #2ms;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      logic signed [W-1:0] ar, ai, br, bi;
      cau_op_type          op;
      int                  wait_cycles;

      idle_pct = 11;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: range ends, every op, zero divisors, conj of the minimum
      send_beat(OP_ADD, MAX_W, MIN_W, MAX_W, MIN_W);
      send_beat(OP_SUB, MIN_W, MAX_W, MAX_W, MIN_W);
      send_beat(OP_SUB, 0, 0, MIN_W, MIN_W);
      send_beat(OP_MUL, MIN_W, MIN_W, MIN_W, MIN_W);
      send_beat(OP_MUL, MAX_W, MIN_W, MAX_W, MAX_W);
      send_beat(OP_MUL, 1, -1, 2048, -2048);
      send_beat(OP_DIV, 4096, 4096, 0, 0);
      send_beat(OP_DIV, MAX_W, MIN_W, 1, 0);
      send_beat(OP_DIV, 100, -100, 4096, 4096);
      send_beat(OP_SCALE, MIN_W, MAX_W, MIN_W, 0);
      send_beat(OP_SCALE, 1, -1, 2048, MAX_W);
      send_beat(OP_CONJ, MIN_W, MIN_W, 5, 5);
      send_beat(OP_CONJ, MAX_W, MAX_W, 0, 0);
      send_beat(OP_INV, 0, 0, 1, 1);
      send_beat(OP_INV, 1, 0, 0, 0);
      send_beat(OP_INV, MIN_W, MIN_W, 0, 0);
      send_beat(OP_INV, 4096, -4096, 0, 0);
      send_beat(OP_DIVR, 4096, 4096, 0, 7);
      send_beat(OP_DIVR, MIN_W, MAX_W, -1, 0);
      send_beat(OP_DIVR, MAX_W, MIN_W, MIN_W, MAX_W);
      send_beat(OP_DIVR, 3, -3, 6, 0);

      // random beats over three idling phases
      for (int n = 0; n < 1530; n++) begin
         if (n == 510) idle_pct = 70;
         if (n == 1020) idle_pct = 0;
         op = cau_op_type'($urandom_range(7));
         ar = pick_value();
         ai = pick_value();
         br = pick_value();
         bi = pick_value();
         send_beat(op, ar, ai, br, bi);
      end
      start <= 0;

      // drain the pipeline
      wait_cycles = 0;
      while (sb.expected_q.size() != 0 && wait_cycles < 1000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (W + 16) @(posedge clock);
      if (sb.expected_q.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, sb.expected_q.size());
         sb.errors++;
      end
      if (sb.errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

### complex_arithmetic_unit_core.f
hdl/cau_pkg.sv
hdl/cau_div_cell.sv
hdl/cau_divider.sv
hdl/complex_arithmetic_unit_core.sv
test/tb.sv
